// ===== rtl/core/priority_ready_queue_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRQ_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define PRQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// ===== rtl/core/prq_pkg.sv =====
// Package with sizes, codes and beat types of the priority ready queue scheduler.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Input kinds
  localparam logic [1:0] K_ADD   = 2'd0;
  localparam logic [1:0] K_YIELD = 2'd1;
  localparam logic [1:0] K_START = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ALONE = 2'd1;
  localparam logic [1:0] ST_FAULT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_BITS-1:0]   proc_id;
    logic [PRIO_BITS-1:0] proc_priority;
  } item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] running_id;
    logic               running_valid;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  // Access request from the sequencer to the queue store, indexes are queue positions
  typedef struct packed {
    logic                rd_en;
    logic [PTR_BITS-1:0] rd_idx;
    logic                wr_en;
    logic [PTR_BITS-1:0] wr_idx;
    entry_t              wr_entry;
  } store_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/priority_ready_queue_scheduler.sv =====
// Top level of the priority ready queue scheduler: sequencer, running register, result beat.
//
// Usage: drive item and raise start; the beat is taken at an edge where start is high
// and busy is low. Each beat yields exactly one result beat, shown on result for one
// cycle with done high; the receiver must take it then, it cannot stall the block.
// The ready queue lives in a circular memory (one registered read, one write per cycle),
// sorted by descending priority, first in first out among equal priorities.
// Steps per beat:
//   fault, alone, full-drop: result straight from idle
//   start: head read, then pop into the running register
//   add: tail read, then the insert walk moves back the entries with lower priority
//   yield: head read, then as add with the old runner; no walk when the runner outranks the head
// The insert walk moves one entry per cycle through the memory port pair. busy stays
// high until done; a new beat may be accepted in the done cycle.
// Reads and writes never hit the same entry in one cycle, so no forwarding is needed.
// Reset (rst, synchronous) empties the queue and clears the running register; the
// memory content is not cleared and is only read below the fill count.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_ready_queue_scheduler_assert.svh"
module priority_ready_queue_scheduler (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire prq_pkg::item_t  item,
  output logic                 busy,
  output logic                 done,
  output prq_pkg::result_t     result
);
  import prq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;

  localparam logic [CNT_BITS-1:0] CNT_DEPTH = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] PTR_LAST  = PTR_BITS'(QUEUE_DEPTH - 1);

  logic [2:0]           state;
  logic [CNT_BITS-1:0]  count;
  logic [PTR_BITS-1:0]  head;
  logic [PTR_BITS-1:0]  pos;
  logic [ID_BITS-1:0]   run_id;
  logic [PRIO_BITS-1:0] run_prio;
  logic                 run_valid;
  logic [1:0]           op_kind;
  entry_t               ins;

  store_req_t           req;
  entry_t               rd_data;

  logic                 accept;
  logic                 hd_read;
  logic                 stop;
  logic [CNT_BITS-1:0]  cnt_m1;
  logic [PTR_BITS-1:0]  head_inc;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign hd_read  = accept && (count != '0) &&
                    (((item.kind == K_YIELD) && run_valid) || (item.kind == K_START));
  assign stop     = (rd_data.prio >= ins.prio);
  assign cnt_m1   = count - 1'b1;
  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;

  // Drive memory accesses for the current step
  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        req.rd_en = hd_read;
      end
      S_INS: begin
        req.rd_en  = (count != '0);
        req.rd_idx = cnt_m1[PTR_BITS-1:0];
      end
      S_WALK: begin
        req.wr_en    = 1'b1;
        req.wr_idx   = pos;
        req.wr_entry = stop ? ins : rd_data;
        if (!stop && (pos != PTR_BITS'(1))) begin
          req.rd_en  = 1'b1;
          req.rd_idx = pos - PTR_BITS'(2);
        end
      end
      S_PLACE: begin
        req.wr_en    = 1'b1;
        req.wr_idx   = pos;
        req.wr_entry = ins;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  prq_store u_store (
    .clk     (clk),
    .head    (head),
    .req     (req),
    .rd_data (rd_data)
  );

  // Sequence items, hold the running register and emit the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      run_id    <= '0;
      run_prio  <= '0;
      run_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_kind <= item.kind;
            case (item.kind)
              K_ADD: begin
                if (count == CNT_DEPTH) begin
                  done   <= 1'b1;
                  result <= '{running_id: run_id, running_valid: run_valid, status: ST_FULL};
                end else begin
                  ins   <= '{id: item.proc_id, prio: item.proc_priority};
                  state <= S_INS;
                end
              end
              K_YIELD: begin
                if (!run_valid) begin
                  done   <= 1'b1;
                  result <= '{running_id: run_id, running_valid: run_valid, status: ST_FAULT};
                end else if (count == '0) begin
                  done   <= 1'b1;
                  result <= '{running_id: run_id, running_valid: run_valid, status: ST_ALONE};
                end else begin
                  state <= S_HEAD;
                end
              end
              K_START: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  result <= '{running_id: run_id, running_valid: run_valid, status: ST_FAULT};
                end else begin
                  state <= S_HEAD;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{running_id: run_id, running_valid: run_valid, status: ST_FAULT};
              end
            endcase
          end
        end
        // Head entry is on rd_data: keep the runner or pop the head
        S_HEAD: begin
          if ((op_kind == K_YIELD) && (run_prio > rd_data.prio)) begin
            done   <= 1'b1;
            result <= '{running_id: run_id, running_valid: run_valid, status: ST_OK};
            state  <= S_IDLE;
          end else begin
            run_id    <= rd_data.id;
            run_prio  <= rd_data.prio;
            run_valid <= 1'b1;
            head      <= head_inc;
            count     <= cnt_m1;
            if (op_kind == K_YIELD) begin
              ins   <= '{id: run_id, prio: run_prio};
              state <= S_INS;
            end else begin
              done   <= 1'b1;
              result <= '{running_id: rd_data.id, running_valid: 1'b1, status: ST_OK};
              state  <= S_IDLE;
            end
          end
        end
        // Open the insert walk at the tail
        S_INS: begin
          pos   <= count[PTR_BITS-1:0];
          state <= (count == '0) ? S_PLACE : S_WALK;
        end
        // Move lower-priority entries back one slot until the new entry fits
        S_WALK: begin
          if (stop) begin
            count  <= count + 1'b1;
            done   <= 1'b1;
            result <= '{running_id: run_id, running_valid: run_valid, status: ST_OK};
            state  <= S_IDLE;
          end else begin
            pos <= pos - 1'b1;
            if (pos == PTR_BITS'(1)) begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          count  <= count + 1'b1;
          done   <= 1'b1;
          result <= '{running_id: run_id, running_valid: run_valid, status: ST_OK};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PRQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CNT_DEPTH)
  `PRQ_ASSERT_NEXT(a_accept_progress, clk, rst, accept, busy || done)
  `PRQ_ASSERT_IMPLY(a_full_drop, clk, rst, done && (result.status == ST_FULL), count == CNT_DEPTH)
  `PRQ_ASSERT_IMPLY(a_walk_pos, clk, rst, state == S_WALK, pos != '0)

endmodule
`default_nettype wire

// ===== rtl/core/prq_store.sv =====
// Circular queue store: maps queue positions onto a one-port-read, one-port-write memory.
`timescale 1ns / 1ps
`default_nettype none
module prq_store (
  input  wire logic                         clk,
  input  wire logic [prq_pkg::PTR_BITS-1:0] head,
  input  wire prq_pkg::store_req_t          req,
  output prq_pkg::entry_t                   rd_data
);
  import prq_pkg::*;

  localparam logic [PTR_BITS:0] DEPTH_W = (PTR_BITS + 1)'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];

  logic [PTR_BITS:0]   rd_sum;
  logic [PTR_BITS:0]   wr_sum;
  logic [PTR_BITS-1:0] rd_addr;
  logic [PTR_BITS-1:0] wr_addr;

  // Offset the queue position by the head and wrap once
  always_comb begin
    rd_sum  = {1'b0, head} + {1'b0, req.rd_idx};
    wr_sum  = {1'b0, head} + {1'b0, req.wr_idx};
    rd_addr = (rd_sum >= DEPTH_W) ? PTR_BITS'(rd_sum - DEPTH_W) : rd_sum[PTR_BITS-1:0];
    wr_addr = (wr_sum >= DEPTH_W) ? PTR_BITS'(wr_sum - DEPTH_W) : wr_sum[PTR_BITS-1:0];
  end

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_entry;
    end
  end

  // Registered read port, holds its data when idle
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_priority_ready_queue_scheduler.sv =====
// Self-checking testbench for the priority ready queue scheduler.
`timescale 1ns / 1ps

class sched_tracker;
  prq_pkg::entry_t  ready_list[$];
  prq_pkg::entry_t  running = '0;
  bit               running_valid = 1'b0;
  prq_pkg::result_t pending_results[$];
  int unsigned      errors = 0;
  int unsigned      kind_seen[4] = '{default: 0};
  int unsigned      status_seen[4] = '{default: 0};
  int unsigned      deepest = 0;

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Place an entry behind every entry of equal or higher priority.
  function void queue_by_priority(prq_pkg::entry_t fresh);
    int pos;
    pos = 0;
    while (pos < ready_list.size() && ready_list[pos].prio >= fresh.prio) pos++;
    ready_list.insert(pos, fresh);
  endfunction

  // Apply one accepted input beat and hold the result it must produce.
  function void take_item(prq_pkg::item_t beat);
    prq_pkg::entry_t  fresh;
    prq_pkg::entry_t  prev;
    prq_pkg::result_t want;
    want.status = prq_pkg::ST_OK;
    kind_seen[beat.kind]++;
    case (beat.kind)
      prq_pkg::K_ADD: begin
        if (ready_list.size() >= prq_pkg::QUEUE_DEPTH) begin
          want.status = prq_pkg::ST_FULL;
        end else begin
          fresh.id   = beat.proc_id;
          fresh.prio = beat.proc_priority;
          queue_by_priority(fresh);
        end
      end
      prq_pkg::K_YIELD: begin
        if (!running_valid) begin
          want.status = prq_pkg::ST_FAULT;
        end else if (ready_list.size() == 0) begin
          want.status = prq_pkg::ST_ALONE;
        end else if (running.prio <= ready_list[0].prio) begin
          // swap the running process with the head; a stronger runner just stays
          prev    = running;
          running = ready_list.pop_front();
          queue_by_priority(prev);
        end
      end
      prq_pkg::K_START: begin
        if (ready_list.size() == 0) begin
          want.status = prq_pkg::ST_FAULT;
        end else begin
          // the old runner is dropped, not requeued
          running       = ready_list.pop_front();
          running_valid = 1'b1;
        end
      end
      default: want.status = prq_pkg::ST_FAULT;
    endcase
    if (ready_list.size() > deepest) deepest = ready_list.size();
    want.running_id    = running.id;
    want.running_valid = running_valid;
    status_seen[want.status]++;
    pending_results.push_back(want);
  endfunction

  // Compare a result beat against the oldest expectation.
  function void check_result(prq_pkg::result_t got);
    prq_pkg::result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat: id %0d valid %0d status %0d",
               $time, got.running_id, got.running_valid, got.status);
      return;
    end
    want = pending_results.pop_front();
    if (got.running_id !== want.running_id || got.running_valid !== want.running_valid ||
        got.status !== want.status) begin
      errors++;
      $display("%0t: result mismatch: expected id %0d valid %0d status %0d",
               $time, want.running_id, want.running_valid, want.status,
               ", got id %0d valid %0d status %0d",
               got.running_id, got.running_valid, got.status);
    end
  endfunction
endclass

module tb_priority_ready_queue_scheduler;
  import prq_pkg::*;

  localparam logic [1:0] K_UNKNOWN = 2'd3;
  localparam int ITEM_COUNT = 1800;
  localparam int PHASE_LEN  = 150;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;

  sched_tracker tracker = new;

  priority_ready_queue_scheduler DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check result beats and record accepted beats at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_result(result);
      if (start && !busy) tracker.take_item(item);
    end
  end

  function automatic item_t beat_of(logic [1:0] kind, logic [ID_BITS-1:0] id,
                                    logic [PRIO_BITS-1:0] prio);
    item_t beat;
    beat.kind          = kind;
    beat.proc_id       = id;
    beat.proc_priority = prio;
    return beat;
  endfunction

  // Draw a beat; narrow priority sets force many ties.
  function automatic item_t random_item(int unsigned add_pct, int unsigned yield_pct);
    item_t       beat;
    int unsigned roll;
    beat.proc_id = ID_BITS'($urandom_range((1 << ID_BITS) - 1));
    case ($urandom_range(3))
      0: beat.proc_priority = PRIO_BITS'($urandom_range(3));
      1: beat.proc_priority = $urandom_range(1) ? '1 : '0;
      default: beat.proc_priority = PRIO_BITS'($urandom_range((1 << PRIO_BITS) - 1));
    endcase
    roll = $urandom_range(99);
    if (roll < add_pct) beat.kind = K_ADD;
    else if (roll < add_pct + yield_pct) beat.kind = K_YIELD;
    else if (roll < 97) beat.kind = K_START;
    else beat.kind = K_UNKNOWN;
    return beat;
  endfunction

  // Present one beat, with an optional gap first, and hold it until taken.
  task automatic send_item(input item_t beat, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 8);
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= beat;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every expected result has come back.
  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int          n;
    int unsigned add_pct;
    int unsigned yield_pct;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: faults on an empty block, ties, outranking yield, lone yield.
    send_item(beat_of(K_START, 8'h5a, 8'ha5), 1'b0);
    send_item(beat_of(K_YIELD, 8'hff, 8'hff), 1'b0);
    send_item(beat_of(K_UNKNOWN, 8'h3c, 8'hc3), 1'b0);
    send_item(beat_of(K_ADD, 8'hff, 8'hff), 1'b0);
    send_item(beat_of(K_ADD, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_ADD, 8'h11, 8'h80), 1'b0);
    send_item(beat_of(K_ADD, 8'h22, 8'h80), 1'b0);
    send_item(beat_of(K_START, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_YIELD, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_START, 8'hff, 8'h00), 1'b0);
    send_item(beat_of(K_YIELD, 8'h00, 8'hff), 1'b0);
    send_item(beat_of(K_START, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_START, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_YIELD, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_START, 8'h00, 8'h00), 1'b0);
    send_item(beat_of(K_UNKNOWN, 8'h00, 8'h00), 1'b0);
    drain_results();

    // Random: rotate fill, drain and mixed phases so the queue hits full and empty.
    for (n = 0; n < ITEM_COUNT; n++) begin
      if (n % 300 == 299) drain_results();
      case ((n / PHASE_LEN) % 3)
        0: begin add_pct = 65; yield_pct = 15; end
        1: begin add_pct = 15; yield_pct = 35; end
        default: begin add_pct = 40; yield_pct = 30; end
      endcase
      send_item(random_item(add_pct, yield_pct), !(n >= 600 && n < 900));
    end
    drain_results();
    repeat (30) @(posedge clk);

    $display("Covered beats: add %0d, yield %0d, start %0d, unknown %0d;",
             tracker.kind_seen[K_ADD], tracker.kind_seen[K_YIELD], tracker.kind_seen[K_START],
             tracker.kind_seen[K_UNKNOWN], " deepest queue %0d of %0d",
             tracker.deepest, QUEUE_DEPTH);
    $display("Results by status: ok %0d, alone %0d, fault %0d, full %0d",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_ALONE],
             tracker.status_seen[ST_FAULT], tracker.status_seen[ST_FULL]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
